### sv/pcbp_pkg.sv
// Shared types and constants of the prefix-code bit packer.
package pcbp_pkg;

  localparam int unsigned CMD_W  = 2;
  localparam int unsigned SYM_BITS = 8;
  localparam int unsigned CODE_W = 50;
  localparam int unsigned LEN_W  = 6;
  localparam int unsigned BYTE_W = 8;
  // Aligned code window: wide enough for the longest legal code length
  localparam int unsigned WORD_W = 56;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W = 2;
  localparam int unsigned QCNT_W = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_ENCODE = 2'd1,
    CMD_FLUSH  = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [SYM_BITS-1:0] symbol;
    logic [CODE_W-1:0]   code_word;
    logic [LEN_W-1:0]    code_length;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] packed_byte;
    logic              last;
  } out_item_t;

  // Work for the packing back end: a flush, or a left-aligned code
  typedef struct packed {
    logic              is_flush;
    logic [LEN_W-1:0]  len;
    logic [WORD_W-1:0] word;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } push_t;

endpackage

### sv/pcbp_stream_if.sv
// Valid/ready stream channel carrying one payload item per transfer.
interface pcbp_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### sv/pcbp_front.sv
// Front end: accepts commands, owns the code table, classifies work for the queue.
module pcbp_front import pcbp_pkg::*; #(
  parameter int unsigned MAX_CODE_BITS = 50,
  parameter int unsigned SYMBOL_COUNT  = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_valid_i,
  input  in_item_t          item_i,
  output logic              item_ready_o,
  input  logic [QCNT_W-1:0] q_count_i,
  output push_t             push_o
);

  localparam int unsigned SYM_W = $clog2(SYMBOL_COUNT);

  logic [CODE_W-1:0] code_mem [SYMBOL_COUNT];
  logic [LEN_W-1:0]  len_mem [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] loaded_q;

  logic [CODE_W-1:0] rd_code_q;
  logic [LEN_W-1:0]  rd_len_q;
  logic              s1_hit_q;
  logic              s1_enc_q;
  logic              s1_flush_q;

  logic              accept;
  logic              in_range;
  logic [SYM_W-1:0]  idx;
  logic              do_load;
  logic [LEN_W-1:0]  len_sat;
  logic [LEN_W-1:0]  eff_len;
  logic              s1_busy;

  // Classify the incoming transfer
  assign accept   = item_valid_i && item_ready_o;
  assign in_range = {1'b0, item_i.symbol} < (SYM_BITS + 1)'(SYMBOL_COUNT);
  assign idx      = item_i.symbol[SYM_W-1:0];
  assign do_load  = accept && (item_i.command == CMD_LOAD) && in_range;
  assign len_sat  = (item_i.code_length > LEN_W'(MAX_CODE_BITS)) ?
                    LEN_W'(MAX_CODE_BITS) : item_i.code_length;

  // Leave room in the queue for the item in the lookup stage
  assign s1_busy      = s1_enc_q || s1_flush_q;
  assign item_ready_o = (q_count_i + QCNT_W'(s1_busy)) < QCNT_W'(QUEUE_DEPTH);

  // Table write and registered lookup
  always_ff @(posedge clk_i) begin
    if (do_load) begin
      code_mem[idx] <= item_i.code_word;
      len_mem[idx]  <= len_sat;
    end
    rd_code_q <= code_mem[idx];
    rd_len_q  <= len_mem[idx];
  end

  // Track loaded entries; an unloaded entry reads as length zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q   <= '0;
      s1_hit_q   <= 1'b0;
      s1_enc_q   <= 1'b0;
      s1_flush_q <= 1'b0;
    end else begin
      if (do_load) begin
        loaded_q[idx] <= 1'b1;
      end
      s1_hit_q   <= loaded_q[idx];
      s1_enc_q   <= accept && (item_i.command == CMD_ENCODE) && in_range;
      s1_flush_q <= accept && (item_i.command == CMD_FLUSH);
    end
  end

  // Align the code so its first bit sits at the top; drop empty codes
  assign eff_len = s1_hit_q ? rd_len_q : '0;

  always_comb begin
    push_o.valid        = s1_flush_q || (s1_enc_q && (eff_len != '0));
    push_o.job.is_flush = s1_flush_q;
    push_o.job.len      = eff_len;
    push_o.job.word     = WORD_W'(rd_code_q) << (LEN_W'(WORD_W) - eff_len);
  end

endmodule

### sv/pcbp_queue.sv
// Short job queue between the front end and the packing back end.
module pcbp_queue import pcbp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  push_t             push_i,
  input  logic              pop_i,
  output logic              head_valid_o,
  output job_t              head_o,
  output logic [QCNT_W-1:0] count_o
);

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  assign head_valid_o = count_q != '0;
  assign head_o       = slots[rd_ptr_q];
  assign count_o      = count_q;

  // Store pushed jobs
  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      slots[wr_ptr_q] <= push_i.job;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i.valid) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_q + QCNT_W'(push_i.valid) - QCNT_W'(pop_i);
    end
  end

endmodule

### sv/pcbp_back.sv
// Back end: merges code bits into the byte accumulator and emits packed bytes.
module pcbp_back import pcbp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      head_valid_i,
  input  job_t      head_i,
  output logic      pop_o,
  output logic      out_valid_o,
  output out_item_t out_o,
  input  logic      out_ready_i
);

  logic [BYTE_W-1:0] acc_q, acc_d;
  logic [2:0]        fill_q, fill_d;
  logic              act_q, act_d;
  logic [WORD_W-1:0] word_q, word_d;
  logic [LEN_W-1:0]  rem_q, rem_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  logic              out_free;
  logic              use_head;
  logic              step;
  logic [WORD_W-1:0] cur_word;
  logic [LEN_W-1:0]  cur_rem;
  logic [3:0]        space;
  logic [BYTE_W-1:0] merged;
  logic [WORD_W-1:0] word_sh;
  logic [LEN_W-1:0]  rem_after;

  assign out_free  = !out_valid_q || out_ready_i;
  assign use_head  = !act_q && head_valid_i;
  assign step      = out_free && (act_q || head_valid_i);
  assign cur_word  = act_q ? word_q : head_i.word;
  assign cur_rem   = act_q ? rem_q : head_i.len;
  assign space     = 4'd8 - {1'b0, fill_q};
  assign merged    = acc_q | (cur_word[WORD_W-1 -: BYTE_W] >> fill_q);
  assign word_sh   = cur_word << space;
  assign rem_after = cur_rem - LEN_W'(space);
  assign pop_o     = step && use_head;

  // At most one byte of progress per cycle, and only while the output register is free
  always_comb begin
    acc_d       = acc_q;
    fill_d      = fill_q;
    act_d       = act_q;
    word_d      = word_q;
    rem_d       = rem_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (step) begin
      if (use_head && head_i.is_flush) begin
        // Pad and drain a partial byte
        if (fill_q != '0) begin
          out_valid_d       = 1'b1;
          out_d.packed_byte = acc_q;
          out_d.last        = 1'b1;
        end
        acc_d  = '0;
        fill_d = '0;
      end else if (cur_rem >= LEN_W'(space)) begin
        // Complete a byte; keep the tail when under a byte remains
        out_valid_d       = 1'b1;
        out_d.packed_byte = merged;
        out_d.last        = rem_after < LEN_W'(BYTE_W);
        if (rem_after < LEN_W'(BYTE_W)) begin
          acc_d  = word_sh[WORD_W-1 -: BYTE_W];
          fill_d = rem_after[2:0];
          act_d  = 1'b0;
        end else begin
          acc_d  = '0;
          fill_d = '0;
          word_d = word_sh;
          rem_d  = rem_after;
          act_d  = 1'b1;
        end
      end else begin
        // Code fits in the open byte
        acc_d  = merged;
        fill_d = fill_q + cur_rem[2:0];
        act_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      fill_q      <= '0;
      act_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      fill_q      <= fill_d;
      act_q       <= act_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold payload registers without reset
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    rem_q  <= rem_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

### sv/prefix_code_bit_packer.sv
// Prefix-code bit packer: a code table lookup feeds a queue drained by a byte packer.
// Path: lookup registers, then a queue slot, then the registered output byte.
// Throughput: one item per cycle while each item yields at most one byte and the output
// is ready; an encode that completes more bytes holds the packer, one output byte per cycle.
// Reset: loaded flags, accumulator, queue and output clear at once; no clearing pass.
module prefix_code_bit_packer import pcbp_pkg::*; #(
  parameter int unsigned MAX_CODE_BITS = 50,
  parameter int unsigned SYMBOL_COUNT  = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  pcbp_stream_if.sink   in_i,
  pcbp_stream_if.source out_o
);

  push_t             push;
  logic              pop;
  logic              head_valid;
  job_t              head;
  logic [QCNT_W-1:0] q_count;
  out_item_t         out_item;

  pcbp_front #(
    .MAX_CODE_BITS (MAX_CODE_BITS),
    .SYMBOL_COUNT  (SYMBOL_COUNT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (in_i.valid),
    .item_i       (in_i.data),
    .item_ready_o (in_i.ready),
    .q_count_i    (q_count),
    .push_o       (push)
  );

  pcbp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head),
    .count_o      (q_count)
  );

  pcbp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_o.valid),
    .out_o        (out_item),
    .out_ready_i  (out_o.ready)
  );

  assign out_o.data = out_item;

endmodule
